// ----- hdl/tcgr_pkg.sv -----
// Shared types, codes and constants of the text console glyph renderer.
package tcgr_pkg;

  localparam int CURSOR_BITS = 16;
  localparam int GLYPH_SIZE  = 8;
  localparam int FONT_CHARS  = 256;
  localparam int CODE_W      = $clog2(FONT_CHARS);
  localparam int GROW_W      = $clog2(GLYPH_SIZE);
  localparam int FONT_AW     = CODE_W + GROW_W;
  localparam int FONT_DEPTH  = FONT_CHARS * GLYPH_SIZE;
  localparam int GLYPH_BITS  = GLYPH_SIZE * GLYPH_SIZE;
  localparam int PIX_W       = $clog2(GLYPH_BITS);
  localparam int FCNT_W      = GROW_W + 1;
  localparam int WIDTH_W     = 13;
  localparam int ADDR_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1024;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    CMD_PRINT     = 2'd0,
    CMD_SET_COL   = 2'd1,
    CMD_SET_ROW   = 2'd2,
    CMD_LOAD_FONT = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH = 1'b0,
    CFG_FRAME_BASE   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  character;
    logic [31:0] color;
    logic [15:0] position;
    logic [2:0]  font_row;
    logic [7:0]  font_bits;
  } req_t;

  typedef struct packed {
    logic        pixel_write;
    logic [31:0] pixel_address;
    logic [31:0] pixel_color;
    logic [15:0] cursor_column;
    logic [15:0] cursor_row;
    logic        last;
  } res_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic scan;
    logic empty;
  } ctl_t;

  typedef struct packed {
    logic draw;
    logic fetch_done;
    logic glyph_empty;
    logic scan_done;
  } sts_t;

endpackage

// ----- hdl/tcgr_ctrl.sv -----
// Controller state machine that sequences accept, glyph fetch and pixel scan.
module tcgr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tcgr_pkg::sts_t  sts,
  output tcgr_pkg::ctl_t  ctl,
  output logic            busy
);

  tcgr_pkg::state_t state_r;
  tcgr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    unique case (state_r)
      tcgr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.accept = 1'b1;
          if (sts.draw) begin
            state_nxt = tcgr_pkg::ST_FETCH;
          end
        end
      end
      tcgr_pkg::ST_FETCH: begin
        ctl.fetch = 1'b1;
        if (sts.fetch_done) begin
          state_nxt = sts.glyph_empty ? tcgr_pkg::ST_EMPTY : tcgr_pkg::ST_SCAN;
        end
      end
      tcgr_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_EMPTY: begin
        ctl.empty = 1'b1;
        state_nxt = tcgr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/tcgr_dpath.sv -----
// Datapath: configuration, cursor, font memory, glyph buffer and pixel addressing.
module tcgr_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcgr_pkg::ctl_t                      ctl,
  output tcgr_pkg::sts_t                      sts,
  input  tcgr_pkg::req_t                      in_req,
  input  logic                                cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_strobe,
  output tcgr_pkg::res_t                      out_res
);

  localparam int CB = tcgr_pkg::CURSOR_BITS;
  localparam int WW = tcgr_pkg::WIDTH_W;
  localparam int AW = tcgr_pkg::ADDR_W;
  localparam int GB = tcgr_pkg::GLYPH_BITS;
  localparam int GS = tcgr_pkg::GLYPH_SIZE;
  localparam int GW = tcgr_pkg::GROW_W;

  logic [7:0] font_mem [tcgr_pkg::FONT_DEPTH];
  logic [7:0] rd_data_r;

  logic [WW-1:0]                   width_r, width_nxt;
  logic [AW-1:0]                   base_r, base_nxt;
  logic [CB-1:0]                   column_r, column_nxt;
  logic [CB-1:0]                   row_r, row_nxt;
  logic [CB-1:0]                   cell_col_r, cell_col_nxt;
  logic [CB-1:0]                   cell_row_r, cell_row_nxt;
  logic [tcgr_pkg::CODE_W-1:0]     code_r, code_nxt;
  logic [31:0]                     color_r, color_nxt;
  logic [tcgr_pkg::FCNT_W-1:0]     fcnt_r, fcnt_nxt;
  logic [tcgr_pkg::PIX_W-1:0]      pix_r, pix_nxt;
  logic [GB-1:0]                   glyph_r, glyph_nxt;
  logic [AW-1:0]                   prod_r, prod_nxt;
  logic [AW-1:0]                   row_addr_r, row_addr_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  tcgr_pkg::res_t                  out_res_r, out_res_nxt;

  logic [CB-1:0]                   ncol, nrow, tgt, dcol;
  logic [7:0]                      dcode;
  logic [CB-1:0]                   cols_per_line;
  logic [GW-1:0]                   gi;
  logic [CB+GW-1:0]                py0;
  logic [CB+GW-1:0]                px0;
  logic                            is_print, is_ctrl_char;

  assign is_print      = (in_req.command == tcgr_pkg::CMD_PRINT);
  assign is_ctrl_char  = (in_req.character == tcgr_pkg::CH_NEWLINE) ||
                         (in_req.character == tcgr_pkg::CH_RETURN) ||
                         (in_req.character == tcgr_pkg::CH_TAB);
  assign cols_per_line = CB'(width_r[WW-1:GW]);
  assign tgt           = (column_r == '0) ? '0 : column_r - CB'(1);
  assign gi            = fcnt_r[GW-1:0] - GW'(1);
  assign py0           = {cell_row_r, {GW{1'b0}}};
  assign px0           = {cell_col_r, {GW{1'b0}}};

  // Cursor update and drawing cell of the request at the accept port.
  always_comb begin
    ncol  = column_r;
    nrow  = row_r;
    dcol  = column_r;
    dcode = in_req.character;
    unique case (in_req.command)
      tcgr_pkg::CMD_PRINT: begin
        case (in_req.character)
          tcgr_pkg::CH_NEWLINE: begin
            ncol = '0;
            nrow = row_r + CB'(1);
          end
          tcgr_pkg::CH_RETURN: begin
            ncol = '0;
          end
          tcgr_pkg::CH_TAB: begin
            ncol = {column_r[CB-1:GW], {GW{1'b0}}} + CB'(GS);
          end
          tcgr_pkg::CH_BACKSPACE: begin
            dcol  = tgt;
            dcode = tcgr_pkg::CH_SPACE;
            ncol  = tgt;
          end
          default: begin
            ncol = column_r + CB'(1);
          end
        endcase
        if (ncol >= cols_per_line) begin
          ncol = '0;
          nrow = nrow + CB'(1);
        end
      end
      tcgr_pkg::CMD_SET_COL: begin
        ncol = in_req.position;
      end
      tcgr_pkg::CMD_SET_ROW: begin
        nrow = in_req.position;
      end
      tcgr_pkg::CMD_LOAD_FONT: begin
        ncol = column_r;
      end
      default: begin
        ncol = column_r;
      end
    endcase
  end

  always_comb begin
    width_nxt      = width_r;
    base_nxt       = base_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    cell_col_nxt   = cell_col_r;
    cell_row_nxt   = cell_row_r;
    code_nxt       = code_r;
    color_nxt      = color_r;
    fcnt_nxt       = fcnt_r;
    pix_nxt        = pix_r;
    glyph_nxt      = glyph_r;
    prod_nxt       = prod_r;
    row_addr_nxt   = row_addr_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;

    if (cfg_we) begin
      unique case (cfg_index)
        tcgr_pkg::CFG_SCREEN_WIDTH: width_nxt = cfg_data[WW-1:0];
        tcgr_pkg::CFG_FRAME_BASE:   base_nxt  = cfg_data[AW-1:0];
        default:                    base_nxt  = base_r;
      endcase
    end

    if (ctl.accept) begin
      column_nxt   = ncol;
      row_nxt      = nrow;
      cell_col_nxt = dcol;
      cell_row_nxt = row_r;
      code_nxt     = dcode[tcgr_pkg::CODE_W-1:0];
      color_nxt    = in_req.color;
      fcnt_nxt     = '0;
      pix_nxt      = '0;
      if (!(is_print && !is_ctrl_char)) begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = '{pixel_write: 1'b0, pixel_address: '0, pixel_color: '0,
                           cursor_column: ncol, cursor_row: nrow, last: 1'b1};
      end
    end

    if (ctl.fetch) begin
      fcnt_nxt = fcnt_r + tcgr_pkg::FCNT_W'(1);
      if (fcnt_r == '0) begin
        prod_nxt = AW'(py0) * AW'(width_r);
      end
      if (fcnt_r == tcgr_pkg::FCNT_W'(1)) begin
        row_addr_nxt = base_r + ((prod_r + AW'(px0)) << 2);
      end
      if (fcnt_r != '0) begin
        glyph_nxt[{gi, {GW{1'b0}}} +: GS] = rd_data_r;
      end
    end

    if (ctl.scan) begin
      glyph_nxt = glyph_r >> 1;
      pix_nxt   = pix_r + tcgr_pkg::PIX_W'(1);
      if (pix_r[GW-1:0] == {GW{1'b1}}) begin
        row_addr_nxt = row_addr_r + AW'({width_r, 2'b00});
      end
      if (glyph_r[0]) begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = '{pixel_write: 1'b1,
                           pixel_address: row_addr_r + AW'({pix_r[GW-1:0], 2'b00}),
                           pixel_color: color_r,
                           cursor_column: column_r, cursor_row: row_r,
                           last: (glyph_r[GB-1:1] == '0)};
      end
    end

    if (ctl.empty) begin
      out_strobe_nxt = 1'b1;
      out_res_nxt    = '{pixel_write: 1'b0, pixel_address: '0, pixel_color: '0,
                         cursor_column: column_r, cursor_row: row_r, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= tcgr_pkg::WIDTH_RESET;
      base_r       <= '0;
      column_r     <= '0;
      row_r        <= '0;
      fcnt_r       <= '0;
      pix_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      width_r      <= width_nxt;
      base_r       <= base_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      fcnt_r       <= fcnt_nxt;
      pix_r        <= pix_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_col_r <= cell_col_nxt;
    cell_row_r <= cell_row_nxt;
    code_r     <= code_nxt;
    color_r    <= color_nxt;
    glyph_r    <= glyph_nxt;
    prod_r     <= prod_nxt;
    row_addr_r <= row_addr_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && (in_req.command == tcgr_pkg::CMD_LOAD_FONT)) begin
      font_mem[{in_req.character[tcgr_pkg::CODE_W-1:0], in_req.font_row}] <= in_req.font_bits;
    end
    rd_data_r <= font_mem[{code_r, fcnt_r[GW-1:0]}];
  end

  assign sts.draw        = is_print && !is_ctrl_char;
  assign sts.fetch_done  = (fcnt_r == tcgr_pkg::FCNT_W'(GS));
  assign sts.glyph_empty = (glyph_r[GB-GS-1:0] == '0) && (rd_data_r == '0);
  assign sts.scan_done   = (glyph_r[GB-1:1] == '0);

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_nopix_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_res_r.pixel_write |-> out_res_r.last)
    else $error("request without pixel write gave a result that is not last");

  a_nopix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_res_r.pixel_write |->
      (out_res_r.pixel_address == '0) && (out_res_r.pixel_color == '0))
    else $error("result without pixel write carries address or color");

  a_scan_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan |-> glyph_r != '0)
    else $error("pixel scan running on an empty glyph");

  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fetch |-> fcnt_r <= tcgr_pkg::FCNT_W'(GS))
    else $error("glyph fetch counter ran past the last glyph row");

endmodule

// ----- hdl/text_console_glyph_renderer.sv -----
// Top level of the text console glyph renderer.
// A request is taken at a rising edge where start is high and busy is low.
// Commands: print a character, set the cursor column, set the cursor row,
// or load one 8-bit row of a glyph into the 2048-entry font memory.
// Configuration (screen width, frame base) is written through cfg_we,
// cfg_index and cfg_data, and takes effect at once; write only while idle.
// Each request gives one or more results on out_res, each shown for exactly
// one cycle with out_strobe high; the receiver has no way to stall them.
// Set, load, newline, return and tab requests give a single result one cycle
// after acceptance and keep busy low, so one such request can enter per cycle.
// A printed glyph, backspace included, is fetched row by row from the font
// memory, then its 64 bits are scanned one per cycle, with one result per set
// bit; the scan stops at the last set bit. Busy stays high while the glyph is
// fetched and scanned, so no new request is taken before a print is through;
// a blank glyph skips the scan and gives one result.
// The glyph fetch and the bit-serial scan set the rate of printed glyphs.
// Synchronous reset clears the cursor, restores the default configuration
// and returns to idle; the font memory is not cleared and must be loaded.
module text_console_glyph_renderer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  tcgr_pkg::req_t                   in_req,
  output logic                             out_strobe,
  output tcgr_pkg::res_t                   out_res,
  input  logic                             cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tcgr_pkg::ctl_t ctl;
  tcgr_pkg::sts_t sts;

  tcgr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  tcgr_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the text console glyph renderer with a behavioral predictor.
module tb_top;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 42;
  localparam logic [7:0]  GLYPH_SOLID  = 8'h00;
  localparam logic [7:0]  GLYPH_CORNER = 8'hFF;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  tcgr_pkg::req_t                  in_req;
  logic                            out_strobe;
  tcgr_pkg::res_t                  out_res;
  logic                            cfg_we;
  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [tcgr_pkg::WIDTH_W-1:0] scr_width;
  logic [31:0]                  fb_base;
  logic [15:0]                  cur_col;
  logic [15:0]                  cur_row;
  logic [7:0]                   glyph_mem [tcgr_pkg::FONT_DEPTH];
  logic [7:0]                   rows_loaded [tcgr_pkg::FONT_CHARS];
  tcgr_pkg::res_t               predicted_outputs [$];
  tcgr_pkg::res_t               cell_writes [$];
  int unsigned                  requests_sent = 0;
  int unsigned                  mismatches = 0;
  int unsigned                  idle_cycles = 0;
  bit                           gaps_on;

  text_console_glyph_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_prediction();
    scr_width = tcgr_pkg::WIDTH_RESET;
    fb_base   = '0;
    cur_col   = '0;
    cur_row   = '0;
    predicted_outputs.delete();
    foreach (rows_loaded[c]) rows_loaded[c] = '0;
  endfunction

  function automatic void draw_cell(logic [7:0] code, logic [15:0] cx, logic [15:0] cy,
                                    logic [31:0] color);
    logic [31:0]    py;
    logic [31:0]    px;
    tcgr_pkg::res_t w;
    for (int iy = 0; iy < tcgr_pkg::GLYPH_SIZE; iy++) begin
      for (int ix = 0; ix < tcgr_pkg::GLYPH_SIZE; ix++) begin
        if (glyph_mem[{code, 3'(iy)}][ix]) begin
          py = 32'(cy) * 32'd8 + 32'(iy);
          px = 32'(cx) * 32'd8 + 32'(ix);
          w = '0;
          w.pixel_write   = 1'b1;
          w.pixel_address = fb_base + 32'd4 * (py * 32'(scr_width) + px);
          w.pixel_color   = color;
          cell_writes.push_back(w);
        end
      end
    end
  endfunction

  function automatic void render_request(tcgr_pkg::req_t r);
    logic [15:0]    target;
    tcgr_pkg::res_t blank;
    blank = '0;
    cell_writes.delete();
    case (r.command)
      tcgr_pkg::CMD_PRINT: begin
        case (r.character)
          tcgr_pkg::CH_NEWLINE: begin
            cur_col = '0;
            cur_row = cur_row + 16'd1;
          end
          tcgr_pkg::CH_RETURN: cur_col = '0;
          tcgr_pkg::CH_TAB: cur_col = cur_col - (cur_col % 16'd8) + 16'd8;
          tcgr_pkg::CH_BACKSPACE: begin
            target = (cur_col == 16'd0) ? 16'd0 : cur_col - 16'd1;
            draw_cell(tcgr_pkg::CH_SPACE, target, cur_row, r.color);
            cur_col = target;
          end
          default: begin
            draw_cell(r.character, cur_col, cur_row, r.color);
            cur_col = cur_col + 16'd1;
          end
        endcase
        if (32'(cur_col) >= 32'(scr_width >> 3)) begin
          cur_col = '0;
          cur_row = cur_row + 16'd1;
        end
      end
      tcgr_pkg::CMD_SET_COL: cur_col = r.position;
      tcgr_pkg::CMD_SET_ROW: cur_row = r.position;
      tcgr_pkg::CMD_LOAD_FONT: begin
        glyph_mem[{r.character, r.font_row}] = r.font_bits;
        rows_loaded[r.character][r.font_row] = 1'b1;
      end
    endcase
    if (cell_writes.size() == 0) cell_writes.push_back(blank);
    foreach (cell_writes[k]) begin
      cell_writes[k].cursor_column = cur_col;
      cell_writes[k].cursor_row    = cur_row;
      cell_writes[k].last          = (k == cell_writes.size() - 1);
      predicted_outputs.push_back(cell_writes[k]);
    end
  endfunction

  function automatic tcgr_pkg::req_t make_req(tcgr_pkg::cmd_t c, logic [7:0] ch);
    tcgr_pkg::req_t r;
    r.command   = c;
    r.character = ch;
    r.color     = $urandom();
    r.position  = 16'($urandom());
    r.font_row  = 3'($urandom());
    r.font_bits = 8'($urandom());
    return r;
  endfunction

  function automatic logic [7:0] pick_ready_glyph();
    logic [7:0] ready [$];
    for (int c = 0; c < tcgr_pkg::FONT_CHARS; c++) begin
      if (&rows_loaded[c]) ready.push_back(8'(c));
    end
    return ready[$urandom_range(32'(ready.size() - 1))];
  endfunction

  function automatic logic [15:0] random_position(logic [15:0] span);
    case ($urandom_range(2))
      0: return 16'($urandom_range(32'(span)));
      1: return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_request(tcgr_pkg::req_t r);
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    render_request(r);
    requests_sent++;
    while (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_glyph(logic [7:0] code, logic [63:0] rows);
    tcgr_pkg::req_t r;
    for (int i = 0; i < tcgr_pkg::GLYPH_SIZE; i++) begin
      r = make_req(tcgr_pkg::CMD_LOAD_FONT, code);
      r.font_row  = 3'(i);
      r.font_bits = rows[8*i +: 8];
      send_request(r);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (predicted_outputs.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_screen(logic [tcgr_pkg::WIDTH_W-1:0] width, logic [31:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= tcgr_pkg::CFG_SCREEN_WIDTH;
    cfg_data  <= 32'(width);
    @(posedge clk);
    cfg_index <= tcgr_pkg::CFG_FRAME_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scr_width = width;
    fb_base   = base;
  endtask

  task automatic run_random_traffic(int unsigned count);
    int unsigned    goal;
    int unsigned    pick;
    logic [63:0]    glyph_bits;
    tcgr_pkg::req_t r;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      pick = $urandom_range(99);
      r = make_req(tcgr_pkg::CMD_PRINT, pick_ready_glyph());
      if (pick < 12) begin
        glyph_bits = {$urandom(), $urandom()};
        if ($urandom_range(5) == 0) glyph_bits = '1;
        load_glyph(8'($urandom()), glyph_bits);
      end else if (pick < 18) begin
        r.command   = tcgr_pkg::CMD_LOAD_FONT;
        r.character = 8'($urandom());
        send_request(r);
      end else if (pick < 62) begin
        send_request(r);
      end else if (pick < 78) begin
        case ($urandom_range(3))
          0: r.character = tcgr_pkg::CH_NEWLINE;
          1: r.character = tcgr_pkg::CH_RETURN;
          2: r.character = tcgr_pkg::CH_TAB;
          default: r.character = tcgr_pkg::CH_BACKSPACE;
        endcase
        send_request(r);
      end else if (pick < 89) begin
        r.command  = tcgr_pkg::CMD_SET_COL;
        r.position = random_position(16'(scr_width >> 3));
        send_request(r);
      end else begin
        r.command  = tcgr_pkg::CMD_SET_ROW;
        r.position = random_position(16'd64);
        send_request(r);
      end
    end
  endtask

  task automatic run_screen_phase(logic [tcgr_pkg::WIDTH_W-1:0] width, logic [31:0] base,
                                  bit gaps);
    wait_drained();
    set_screen(width, base);
    gaps_on = gaps;
    run_random_traffic(PHASE_ITEMS);
  endtask

  task automatic test_font_loading();
    load_glyph(GLYPH_SOLID, '1);
    load_glyph(GLYPH_CORNER, 64'h8000_0000_0000_0000);
    load_glyph(tcgr_pkg::CH_SPACE, '0);
  endtask

  task automatic test_glyph_drawing();
    tcgr_pkg::req_t r;
    r = make_req(tcgr_pkg::CMD_PRINT, GLYPH_SOLID);
    r.color = '1;
    send_request(r);
    r = make_req(tcgr_pkg::CMD_PRINT, GLYPH_CORNER);
    r.color = '0;
    send_request(r);
    send_request(make_req(tcgr_pkg::CMD_PRINT, tcgr_pkg::CH_SPACE));
  endtask

  task automatic test_control_characters();
    logic [7:0] codes [5] = '{tcgr_pkg::CH_TAB, tcgr_pkg::CH_BACKSPACE, tcgr_pkg::CH_RETURN,
                              tcgr_pkg::CH_BACKSPACE, tcgr_pkg::CH_NEWLINE};
    foreach (codes[i]) send_request(make_req(tcgr_pkg::CMD_PRINT, codes[i]));
  endtask

  task automatic test_cursor_wrap();
    tcgr_pkg::req_t r;
    r = make_req(tcgr_pkg::CMD_SET_COL, GLYPH_SOLID);
    r.position = 16'hFFFF;
    send_request(r);
    r = make_req(tcgr_pkg::CMD_SET_ROW, GLYPH_SOLID);
    r.position = 16'hFFFF;
    send_request(r);
    send_request(make_req(tcgr_pkg::CMD_PRINT, GLYPH_SOLID));
    r = make_req(tcgr_pkg::CMD_SET_COL, GLYPH_SOLID);
    r.position = 16'hFFFF;
    send_request(r);
    send_request(make_req(tcgr_pkg::CMD_PRINT, tcgr_pkg::CH_TAB));
    send_request(make_req(tcgr_pkg::CMD_PRINT, tcgr_pkg::CH_NEWLINE));
    r = make_req(tcgr_pkg::CMD_SET_COL, GLYPH_SOLID);
    r.position = 16'(scr_width >> 3) - 16'd1;
    send_request(r);
    send_request(make_req(tcgr_pkg::CMD_PRINT, GLYPH_CORNER));
    r = make_req(tcgr_pkg::CMD_SET_COL, GLYPH_SOLID);
    r.position = '0;
    send_request(r);
    r = make_req(tcgr_pkg::CMD_SET_ROW, GLYPH_SOLID);
    r.position = '0;
    send_request(r);
  endtask

  task automatic test_narrow_screen();
    run_screen_phase(13'd8, 32'd0, 1'b1);
  endtask

  task automatic test_widest_screen();
    run_screen_phase(13'd4096, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_back_to_back();
    run_screen_phase(13'($urandom_range(4096, 8)), $urandom(), 1'b0);
  endtask

  task automatic test_random_geometry();
    run_screen_phase(13'($urandom_range(4096, 8)), $urandom(), 1'b1);
    run_screen_phase(13'($urandom_range(64, 8)), 32'hFFFF_F000, 1'b1);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    tcgr_pkg::res_t want;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (predicted_outputs.size() == 0) begin
        mismatches++;
        $error("unexpected result %h", out_res);
      end else begin
        want = predicted_outputs.pop_front();
        compare_field("pixel_write", 32'(want.pixel_write), 32'(out_res.pixel_write));
        compare_field("pixel_address", want.pixel_address, out_res.pixel_address);
        compare_field("pixel_color", want.pixel_color, out_res.pixel_color);
        compare_field("cursor_column", 32'(want.cursor_column),
                      32'(out_res.cursor_column));
        compare_field("cursor_row", 32'(want.cursor_row), 32'(out_res.cursor_row));
        compare_field("last", 32'(want.last), 32'(out_res.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $error("no progress for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= tcgr_pkg::CFG_SCREEN_WIDTH;
    cfg_data  <= '0;
    reset_prediction();
    gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_font_loading();
    test_glyph_drawing();
    test_control_characters();
    test_cursor_wrap();
    test_narrow_screen();
    test_widest_screen();
    test_back_to_back();
    test_random_geometry();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
